// ----- rtl/bfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfm_pkg
// Sizes, types, instruction codes and status codes of the byte tape machine.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int TAPE_DEPTH    = 32768;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int STACK_DEPTH   = 64;

  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  typedef logic [7:0]     byte_t;
  typedef logic [2:0]     status_t;
  typedef logic [TAW-1:0] tape_addr_t;
  typedef logic [PAW-1:0] prog_addr_t;
  typedef logic [PCW-1:0] pc_t;
  typedef logic [SAW-1:0] stack_addr_t;
  typedef logic [SCW-1:0] stack_cnt_t;

  localparam byte_t OP_INC   = 8'h2B;
  localparam byte_t OP_DEC   = 8'h2D;
  localparam byte_t OP_RIGHT = 8'h3E;
  localparam byte_t OP_LEFT  = 8'h3C;
  localparam byte_t OP_WRITE = 8'h2E;
  localparam byte_t OP_READ  = 8'h2C;
  localparam byte_t OP_OPEN  = 8'h5B;
  localparam byte_t OP_CLOSE = 8'h5D;

  localparam status_t ST_OK              = 3'd0;
  localparam status_t ST_HALTED          = 3'd1;
  localparam status_t ST_OVERFLOW        = 3'd2;
  localparam status_t ST_UNMATCHED_CLOSE = 3'd3;
  localparam status_t ST_UNMATCHED_OPEN  = 3'd4;
  localparam status_t ST_FULL            = 3'd5;

endpackage

// ----- rtl/bfm_item_if.sv -----
// ----------------------------------------------------------------------------
// bfm_item_if
// Request channel: program append or single instruction execute.
// ----------------------------------------------------------------------------
interface bfm_item_if;
  logic                valid;
  logic                ready;
  logic                mode;
  bfm_pkg::byte_t      program_byte;
  bfm_pkg::byte_t      input_byte;

  modport source(output valid, output mode, output program_byte, output input_byte,
                 input ready);
  modport sink(input valid, input mode, input program_byte, input input_byte,
               output ready);
endinterface

// ----- rtl/bfm_result_if.sv -----
// ----------------------------------------------------------------------------
// bfm_result_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface bfm_result_if;
  logic                valid;
  logic                ready;
  logic                out_valid;
  bfm_pkg::byte_t      out_byte;
  bfm_pkg::status_t    status;
  logic                next_reads_input;

  modport source(output valid, output out_valid, output out_byte, output status,
                 output next_reads_input, input ready);
  modport sink(input valid, input out_valid, input out_byte, input status,
               input next_reads_input, output ready);
endinterface

// ----- rtl/brainfuck_machine_step_core.sv -----
// ----------------------------------------------------------------------------
// brainfuck_machine_step_core
// Byte tape machine that appends program bytes or executes one instruction
// per request, with tape, program and loop stack held in RAMs.
//
//   channel  direction  contents
//   item     in         mode, program_byte, input_byte
//   result   out        out_valid, out_byte, status, next_reads_input
//
// An execute request passes through execution on the data read at the program
// counter and cell pointer, then the result load, which uses the read of the
// next instruction. An append passes through a look state, then the result load.
// A forward bracket scan on a zero cell steps through the program bytes after
// the bracket, and ends with ST_UNMATCHED_OPEN when no match is found.
// After reset all TAPE_DEPTH (32768) tape cells are swept to zero with
// item.ready low. A result waits in an output register; while it is not taken
// and another one is finished, the machine holds and stops taking requests.
// ----------------------------------------------------------------------------
module brainfuck_machine_step_core (
  input  logic         clk,
  input  logic         rst,
  bfm_item_if.sink     item,
  bfm_result_if.source result
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]              state;
  bfm_pkg::pc_t            pc;
  bfm_pkg::pc_t            len;
  bfm_pkg::tape_addr_t     cp;
  bfm_pkg::stack_cnt_t     sc;
  bfm_pkg::tape_addr_t     clr_addr;
  bfm_pkg::pc_t            scan_k;
  bfm_pkg::pc_t            scan_depth;
  bfm_pkg::byte_t          in_byte;
  bfm_pkg::status_t        st;
  logic                    emit;
  bfm_pkg::byte_t          emit_byte;

  logic                    res_vld;
  logic                    res_out_valid;
  bfm_pkg::byte_t          res_out_byte;
  bfm_pkg::status_t        res_status;
  logic                    res_reads;

  logic                    prog_we;
  bfm_pkg::prog_addr_t     prog_waddr;
  bfm_pkg::byte_t          prog_wdata;
  bfm_pkg::prog_addr_t     prog_raddr;
  bfm_pkg::byte_t          prog_rdata;
  logic                    tape_we;
  bfm_pkg::tape_addr_t     tape_waddr;
  bfm_pkg::byte_t          tape_wdata;
  bfm_pkg::byte_t          tape_rdata;
  logic                    stack_we;
  bfm_pkg::prog_addr_t     stack_rdata;
  bfm_pkg::stack_cnt_t     sc_dec;

  logic                    accept;
  logic                    can_load;
  bfm_pkg::pc_t            pc_inc;
  bfm_pkg::pc_t            scan_next;
  logic                    scan_end;

  bfm_pkg::pc_t            x_pc;
  bfm_pkg::tape_addr_t     x_cp;
  bfm_pkg::stack_cnt_t     x_sc;
  bfm_pkg::status_t        x_st;
  logic                    x_emit;
  logic                    x_scan;
  logic                    x_tape_we;
  bfm_pkg::byte_t          x_tape_wdata;
  logic                    x_push;

  assign can_load  = !res_vld || result.ready;
  assign item.ready = (state == S_IDLE) || ((state == S_FIN) && can_load);
  assign accept    = item.valid && item.ready;
  assign pc_inc    = pc + bfm_pkg::PCW'(1);
  assign scan_next = scan_k + bfm_pkg::PCW'(1);
  assign scan_end  = scan_k >= len;
  assign sc_dec    = sc - bfm_pkg::SCW'(1);

  assign result.valid            = res_vld;
  assign result.out_valid        = res_out_valid;
  assign result.out_byte         = res_out_byte;
  assign result.status           = res_status;
  assign result.next_reads_input = res_reads;

  // Instruction decode and execute for the fetched opcode and cell.
  always_comb begin
    x_pc         = pc;
    x_cp         = cp;
    x_sc         = sc;
    x_st         = bfm_pkg::ST_OK;
    x_emit       = 1'b0;
    x_scan       = 1'b0;
    x_tape_we    = 1'b0;
    x_tape_wdata = tape_rdata;
    x_push       = 1'b0;
    if (pc >= len) begin
      x_st = bfm_pkg::ST_HALTED;
    end else begin
      case (prog_rdata)
        bfm_pkg::OP_INC: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = tape_rdata + 8'd1;
          x_pc         = pc_inc;
        end
        bfm_pkg::OP_DEC: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = tape_rdata - 8'd1;
          x_pc         = pc_inc;
        end
        bfm_pkg::OP_RIGHT: begin
          x_cp = (cp == bfm_pkg::TAW'(bfm_pkg::TAPE_DEPTH - 1)) ? '0
                                                               : cp + bfm_pkg::TAW'(1);
          x_pc = pc_inc;
        end
        bfm_pkg::OP_LEFT: begin
          x_cp = (cp == '0) ? bfm_pkg::TAW'(bfm_pkg::TAPE_DEPTH - 1)
                            : cp - bfm_pkg::TAW'(1);
          x_pc = pc_inc;
        end
        bfm_pkg::OP_WRITE: begin
          x_emit = 1'b1;
          x_pc   = pc_inc;
        end
        bfm_pkg::OP_READ: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = in_byte;
          x_pc         = pc_inc;
        end
        bfm_pkg::OP_OPEN: begin
          if (tape_rdata == 8'd0) begin
            x_scan = 1'b1;
          end else if (sc == bfm_pkg::SCW'(bfm_pkg::STACK_DEPTH)) begin
            x_st = bfm_pkg::ST_OVERFLOW;
          end else begin
            x_push = 1'b1;
            x_sc   = sc + bfm_pkg::SCW'(1);
            x_pc   = pc_inc;
          end
        end
        bfm_pkg::OP_CLOSE: begin
          if (sc == '0) begin
            x_st = bfm_pkg::ST_UNMATCHED_CLOSE;
          end else begin
            x_sc = sc_dec;
            x_pc = (tape_rdata != 8'd0) ? bfm_pkg::PCW'(stack_rdata) : pc_inc;
          end
        end
        default: begin
          x_pc = pc_inc;
        end
      endcase
    end
  end

  always_comb begin
    prog_we    = accept && !item.mode && (len != bfm_pkg::PCW'(bfm_pkg::PROGRAM_DEPTH));
    prog_waddr = len[bfm_pkg::PAW-1:0];
    prog_wdata = item.program_byte;
    prog_raddr = pc[bfm_pkg::PAW-1:0];
    case (state)
      S_EXEC: begin
        prog_raddr = x_scan ? pc_inc[bfm_pkg::PAW-1:0] : x_pc[bfm_pkg::PAW-1:0];
      end
      S_SCAN: begin
        prog_raddr = scan_end ? pc[bfm_pkg::PAW-1:0] : scan_next[bfm_pkg::PAW-1:0];
      end
      default: begin
        prog_raddr = pc[bfm_pkg::PAW-1:0];
      end
    endcase
  end

  assign tape_we    = (state == S_CLEAR) || ((state == S_EXEC) && x_tape_we);
  assign tape_waddr = (state == S_CLEAR) ? clr_addr : cp;
  assign tape_wdata = (state == S_CLEAR) ? 8'd0 : x_tape_wdata;
  assign stack_we   = (state == S_EXEC) && x_push;

  bfm_ram #(.WIDTH(8), .DEPTH(bfm_pkg::PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bfm_ram #(.WIDTH(8), .DEPTH(bfm_pkg::TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (cp),
    .rdata (tape_rdata)
  );

  bfm_ram #(.WIDTH(bfm_pkg::PAW), .DEPTH(bfm_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (sc[bfm_pkg::SAW-1:0]),
    .wdata (pc[bfm_pkg::PAW-1:0]),
    .raddr (sc_dec[bfm_pkg::SAW-1:0]),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      pc       <= '0;
      len      <= '0;
      cp       <= '0;
      sc       <= '0;
      clr_addr <= '0;
      res_vld  <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        res_vld <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + bfm_pkg::TAW'(1);
          if (clr_addr == bfm_pkg::TAW'(bfm_pkg::TAPE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_EXEC: begin
          pc        <= x_pc;
          cp        <= x_cp;
          sc        <= x_sc;
          st        <= x_st;
          emit      <= x_emit;
          emit_byte <= x_emit ? tape_rdata : 8'd0;
          if (x_scan) begin
            scan_k     <= pc_inc;
            scan_depth <= bfm_pkg::PCW'(1);
            state      <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            st    <= bfm_pkg::ST_UNMATCHED_OPEN;
            state <= S_FIN;
          end else if (prog_rdata == bfm_pkg::OP_OPEN) begin
            scan_depth <= scan_depth + bfm_pkg::PCW'(1);
            scan_k     <= scan_next;
          end else if (prog_rdata == bfm_pkg::OP_CLOSE) begin
            if (scan_depth == bfm_pkg::PCW'(1)) begin
              pc    <= scan_next;
              state <= S_FIN;
            end else begin
              scan_depth <= scan_depth - bfm_pkg::PCW'(1);
              scan_k     <= scan_next;
            end
          end else begin
            scan_k <= scan_next;
          end
        end
        S_LOOK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (can_load) begin
            res_vld       <= 1'b1;
            res_out_valid <= emit;
            res_out_byte  <= emit_byte;
            res_status    <= st;
            res_reads     <= (pc < len) && (prog_rdata == bfm_pkg::OP_READ);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        emit      <= 1'b0;
        emit_byte <= 8'd0;
        st        <= bfm_pkg::ST_OK;
        if (!item.mode) begin
          if (len == bfm_pkg::PCW'(bfm_pkg::PROGRAM_DEPTH)) begin
            st <= bfm_pkg::ST_FULL;
          end else begin
            len <= len + bfm_pkg::PCW'(1);
          end
          state <= S_LOOK;
        end else begin
          in_byte <= item.input_byte;
          state   <= S_EXEC;
        end
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= bfm_pkg::SCW'(bfm_pkg::STACK_DEPTH))
    else $error("Loop stack count exceeds its depth.");

  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= len)
    else $error("Program counter runs past the loaded program.");

  a_tape_write_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && tape_we |-> pc < len)
    else $error("Tape written by a halted machine.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !can_load |=> (state == S_FIN) && $stable(pc))
    else $error("Finished result lost while the output register is full.");

endmodule

// ----- rtl/bfm_ram.sv -----
// ----------------------------------------------------------------------------
// bfm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/brainfuck_machine_step_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brainfuck_machine_step_core_tb
// Self-checking testbench for the byte tape machine. Requests append program
// bytes or execute one instruction each. A behavioral model of the machine
// predicts every result as its request is accepted, and the results are
// checked in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module brainfuck_machine_step_core_tb;

  typedef struct packed {
    logic             out_valid;
    bfm_pkg::byte_t   out_byte;
    bfm_pkg::status_t status;
    logic             next_reads_input;
  } result_t;

  logic clk;
  logic rst;

  bfm_item_if   item_ch();
  bfm_result_if result_ch();

  brainfuck_machine_step_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  bfm_pkg::byte_t       tape_mem  [bfm_pkg::TAPE_DEPTH];
  bfm_pkg::byte_t       prog_mem  [bfm_pkg::PROGRAM_DEPTH];
  bfm_pkg::prog_addr_t  loop_pos  [bfm_pkg::STACK_DEPTH];
  bfm_pkg::pc_t         prog_len;
  bfm_pkg::pc_t         pc_model;
  bfm_pkg::tape_addr_t  cell_ptr;
  bfm_pkg::stack_cnt_t  depth_used;

  result_t         pending_results [$];
  bfm_pkg::byte_t  code_buf [$];
  int              error_count;
  int              requests_sent;
  int              receiver_hold;
  bit              no_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic result_t machine_step(logic mode, bfm_pkg::byte_t pb,
                                           bfm_pkg::byte_t ib);
    result_t        r;
    bfm_pkg::byte_t op;
    bfm_pkg::pc_t   k;
    int unsigned    nest;
    r = '0;
    r.status = bfm_pkg::ST_OK;
    if (!mode) begin
      if (prog_len >= bfm_pkg::PCW'(bfm_pkg::PROGRAM_DEPTH)) begin
        r.status = bfm_pkg::ST_FULL;
      end else begin
        prog_mem[prog_len[bfm_pkg::PAW-1:0]] = pb;
        prog_len = prog_len + bfm_pkg::PCW'(1);
      end
    end else if (pc_model >= prog_len) begin
      r.status = bfm_pkg::ST_HALTED;
    end else begin
      op = prog_mem[pc_model[bfm_pkg::PAW-1:0]];
      case (op)
        bfm_pkg::OP_INC: begin
          tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_DEC: begin
          tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_RIGHT: begin
          cell_ptr = cell_ptr + bfm_pkg::TAW'(1);
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_LEFT: begin
          cell_ptr = cell_ptr - bfm_pkg::TAW'(1);
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_WRITE: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_mem[cell_ptr];
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_READ: begin
          tape_mem[cell_ptr] = ib;
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
        bfm_pkg::OP_OPEN: begin
          if (tape_mem[cell_ptr] == 8'd0) begin
            nest = 1;
            k = pc_model + bfm_pkg::PCW'(1);
            while (k < prog_len) begin
              if (prog_mem[k[bfm_pkg::PAW-1:0]] == bfm_pkg::OP_OPEN) begin
                nest++;
              end else if (prog_mem[k[bfm_pkg::PAW-1:0]] == bfm_pkg::OP_CLOSE) begin
                nest--;
                if (nest == 0) break;
              end
              k = k + bfm_pkg::PCW'(1);
            end
            if (k >= prog_len) r.status = bfm_pkg::ST_UNMATCHED_OPEN;
            else pc_model = k + bfm_pkg::PCW'(1);
          end else if (depth_used >= bfm_pkg::SCW'(bfm_pkg::STACK_DEPTH)) begin
            r.status = bfm_pkg::ST_OVERFLOW;
          end else begin
            loop_pos[depth_used[bfm_pkg::SAW-1:0]] = pc_model[bfm_pkg::PAW-1:0];
            depth_used = depth_used + bfm_pkg::SCW'(1);
            pc_model = pc_model + bfm_pkg::PCW'(1);
          end
        end
        bfm_pkg::OP_CLOSE: begin
          if (depth_used == '0) begin
            r.status = bfm_pkg::ST_UNMATCHED_CLOSE;
          end else begin
            depth_used = depth_used - bfm_pkg::SCW'(1);
            if (tape_mem[cell_ptr] != 8'd0) begin
              pc_model = bfm_pkg::PCW'(loop_pos[depth_used[bfm_pkg::SAW-1:0]]);
            end else begin
              pc_model = pc_model + bfm_pkg::PCW'(1);
            end
          end
        end
        default: begin
          pc_model = pc_model + bfm_pkg::PCW'(1);
        end
      endcase
    end
    r.next_reads_input = (pc_model < prog_len) &&
                         (prog_mem[pc_model[bfm_pkg::PAW-1:0]] == bfm_pkg::OP_READ);
    return r;
  endfunction

  task automatic send(logic mode, bfm_pkg::byte_t pb, bfm_pkg::byte_t ib);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= mode;
    item_ch.program_byte <= pb;
    item_ch.input_byte   <= ib;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    pending_results.push_back(machine_step(mode, pb, ib));
    requests_sent++;
  endtask

  task automatic load_byte(bfm_pkg::byte_t b);
    send(1'b0, b, bfm_pkg::byte_t'($urandom));
  endtask

  // A read that sets a loop counter gets a small value so that loops stay short.
  task automatic step_machine();
    bfm_pkg::byte_t ib;
    if (pc_model < prog_len && prog_mem[pc_model[bfm_pkg::PAW-1:0]] == bfm_pkg::OP_READ &&
        (pc_model + bfm_pkg::PCW'(1) >= prog_len ||
         prog_mem[pc_model[bfm_pkg::PAW-1:0] + bfm_pkg::PAW'(1)] == bfm_pkg::OP_OPEN))
      ib = bfm_pkg::byte_t'($urandom_range(0, 3));
    else
      ib = bfm_pkg::byte_t'($urandom);
    send(1'b1, bfm_pkg::byte_t'($urandom), ib);
  endtask

  task automatic run_to_halt();
    int guard;
    guard = 0;
    while (pc_model < prog_len && guard < 3000) begin
      step_machine();
      guard++;
    end
    if ($urandom_range(0, 2) == 0) step_machine();
  endtask

  function automatic void add_plain(bit moves);
    bfm_pkg::byte_t b;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, moves ? 6 : 4))
        0: b = bfm_pkg::OP_INC;
        1: b = bfm_pkg::OP_DEC;
        2: b = bfm_pkg::OP_WRITE;
        3: b = bfm_pkg::OP_READ;
        4: begin
          b = bfm_pkg::byte_t'($urandom);
          if (b == bfm_pkg::OP_OPEN || b == bfm_pkg::OP_CLOSE) b = ~b;
        end
        5: b = bfm_pkg::OP_RIGHT;
        default: b = bfm_pkg::OP_LEFT;
      endcase
      code_buf.push_back(b);
    end
  endfunction

  // Loops count down a cell loaded by the read just before them and work one
  // cell to the right, so every generated program terminates.
  function automatic void add_block(int nest, bit moves);
    repeat ($urandom_range(1, 3)) begin
      if (nest < 2 && $urandom_range(0, 2) == 0) begin
        code_buf.push_back(bfm_pkg::OP_READ);
        code_buf.push_back(bfm_pkg::OP_OPEN);
        code_buf.push_back(bfm_pkg::OP_DEC);
        code_buf.push_back(bfm_pkg::OP_RIGHT);
        add_block(nest + 1, 1'b0);
        code_buf.push_back(bfm_pkg::OP_LEFT);
        code_buf.push_back(bfm_pkg::OP_CLOSE);
      end else begin
        add_plain(moves);
      end
    end
  endfunction

  task automatic test_basic_ops();
    bfm_pkg::byte_t basic_code [12] = '{8'h00, 8'hFF, bfm_pkg::OP_LEFT, bfm_pkg::OP_INC,
                                        bfm_pkg::OP_WRITE, bfm_pkg::OP_RIGHT,
                                        bfm_pkg::OP_DEC, bfm_pkg::OP_WRITE,
                                        bfm_pkg::OP_INC, bfm_pkg::OP_WRITE,
                                        bfm_pkg::OP_READ, bfm_pkg::OP_WRITE};
    step_machine();
    foreach (basic_code[i]) load_byte(basic_code[i]);
    repeat (10) step_machine();
    send(1'b1, 8'h00, 8'hFF);
    repeat (2) step_machine();
  endtask

  task automatic test_brackets();
    load_byte(bfm_pkg::OP_READ);
    load_byte(bfm_pkg::OP_OPEN);
    load_byte(bfm_pkg::OP_INC);
    send(1'b1, bfm_pkg::byte_t'($urandom), 8'h00);
    step_machine();
    load_byte(bfm_pkg::OP_CLOSE);
    repeat (2) step_machine();
    load_byte(bfm_pkg::OP_READ);
    load_byte(bfm_pkg::OP_OPEN);
    load_byte(bfm_pkg::OP_DEC);
    load_byte(bfm_pkg::OP_WRITE);
    load_byte(bfm_pkg::OP_CLOSE);
    send(1'b1, bfm_pkg::byte_t'($urandom), 8'd2);
    repeat (10) step_machine();
  endtask

  task automatic test_backpressure();
    receiver_hold = 80;
    no_gaps = 1'b1;
    repeat (8) begin
      load_byte(bfm_pkg::OP_WRITE);
      step_machine();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_programs();
    int stop_at;
    stop_at = requests_sent + 650;
    while (requests_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      code_buf.delete();
      add_block(0, 1'b1);
      foreach (code_buf[i]) begin
        load_byte(code_buf[i]);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) step_machine();
      end
      run_to_halt();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_stack_overflow();
    load_byte(bfm_pkg::OP_READ);
    repeat (bfm_pkg::STACK_DEPTH + 1) load_byte(bfm_pkg::OP_OPEN);
    send(1'b1, bfm_pkg::byte_t'($urandom), bfm_pkg::byte_t'($urandom_range(1, 255)));
    repeat (bfm_pkg::STACK_DEPTH + 2) step_machine();
  endtask

  task automatic test_unmatched_close();
    load_byte(bfm_pkg::OP_CLOSE);
    repeat (2) step_machine();
  endtask

  task automatic test_program_full();
    while (prog_len < bfm_pkg::PCW'(bfm_pkg::PROGRAM_DEPTH)) begin
      if (prog_len % 512 == 0) no_gaps = ($urandom_range(0, 1) == 0);
      load_byte(bfm_pkg::byte_t'($urandom));
    end
    no_gaps = 1'b0;
    repeat (3) load_byte(bfm_pkg::byte_t'($urandom));
    step_machine();
  endtask

  initial begin
    int gap;
    result_t seen;
    result_t want;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (receiver_hold > 0) begin
        gap = receiver_hold;
        receiver_hold = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 18);
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      seen = {result_ch.out_valid, result_ch.out_byte, result_ch.status,
              result_ch.next_reads_input};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result valid=%0d byte=%02h status=%0d reads=%0d",
                 $time, seen.out_valid, seen.out_byte, seen.status, seen.next_reads_input);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          $display("%0t: expected valid=%0d byte=%02h status=%0d reads=%0d", $time,
                   want.out_valid, want.out_byte, want.status, want.next_reads_input);
          $display("%0t: actual   valid=%0d byte=%02h status=%0d reads=%0d", $time,
                   seen.out_valid, seen.out_byte, seen.status, seen.next_reads_input);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.mode         <= 1'b0;
    item_ch.program_byte <= 8'h00;
    item_ch.input_byte   <= 8'h00;
    foreach (tape_mem[i]) tape_mem[i] = 8'h00;
    foreach (prog_mem[i]) prog_mem[i] = 8'h00;
    foreach (loop_pos[i]) loop_pos[i] = '0;
    prog_len      = '0;
    pc_model      = '0;
    cell_ptr      = '0;
    depth_used    = '0;
    error_count   = 0;
    requests_sent = 0;
    receiver_hold = 0;
    no_gaps       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_brackets();
    test_backpressure();
    test_random_programs();
    // Both of these leave the machine stuck for good, so each run takes one.
    if ($urandom_range(0, 1) == 1) test_stack_overflow();
    else test_unmatched_close();
    test_program_full();

    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
